// ----- hdl/kmd_pkg.sv -----
// Shared types and constants for the k-way merge and dedup unit.
`default_nettype none

package kmd_pkg;

   localparam int NUM_SOURCES_DEFAULT = 16;
   localparam int KEY_WORD_W          = 32;
   localparam int BLOCK_SIZE          = 3;
   localparam int KEY_W               = BLOCK_SIZE * KEY_WORD_W;
   localparam int SOURCE_W            = 4;
   localparam int ACTIVE_W            = 5;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   localparam logic KIND_KEY       = 1'b0;
   localparam logic KIND_EXHAUSTED = 1'b1;

   typedef logic [KEY_W-1:0] key_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT_POP,
      ST_EMIT_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan_step;
      logic emit_pop;
      logic emit_done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pop_ready;
      logic all_done;
      logic scan_last;
      logic slot_free;
   } dp_status_type;

endpackage : kmd_pkg

`default_nettype wire

// ----- hdl/kmd_req_if.sv -----
// Input channel: key beats and exhaustion notices.
`default_nettype none

interface kmd_req_if
   import kmd_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [SOURCE_W-1:0]       source_id;
   logic [KEY_WORD_W-1:0]     key_word0;
   logic [KEY_WORD_W-1:0]     key_word1;
   logic [KEY_WORD_W-1:0]     key_word2;

   modport source (output valid, kind, source_id, key_word0, key_word1, key_word2,
                   input ready);
   modport sink   (input valid, kind, source_id, key_word0, key_word1, key_word2,
                   output ready);
endinterface : kmd_req_if

`default_nettype wire

// ----- hdl/kmd_rsp_if.sv -----
// Result channel: popped keys and completion beats.
`default_nettype none

interface kmd_rsp_if
   import kmd_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [KEY_WORD_W-1:0]     out_word0;
   logic [KEY_WORD_W-1:0]     out_word1;
   logic [KEY_WORD_W-1:0]     out_word2;
   logic                      is_duplicate;
   logic [SOURCE_W-1:0]       fetch_source;
   logic                      merge_done;

   modport source (output valid, out_word0, out_word1, out_word2, is_duplicate,
                   fetch_source, merge_done, input ready);
   modport sink   (input valid, out_word0, out_word1, out_word2, is_duplicate,
                   fetch_source, merge_done, output ready);
endinterface : kmd_rsp_if

`default_nettype wire

// ----- hdl/kway_merge_dedup_unit.sv -----
// Flow: an accepted beat that pops a key is evaluated, then the controller scans the
// head store over N, the effective active source count, to find the minimum (a linear
// scan, one read per cycle), passes a drain state and loads the result register.
// A completion beat loads it directly. Both wait for a free result slot, and no new beat is taken until then.
// Reset (synchronous): clears present and exhausted masks, last-key flag, result
// valid, and sets active_sources to 16; the head store is not cleared.
`default_nettype none

module kway_merge_dedup_unit
   import kmd_pkg::*;
#(
   parameter int NUM_SOURCES = NUM_SOURCES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [ACTIVE_W-1:0] csr_write_data,
   kmd_req_if.sink                  req_bus,
   kmd_rsp_if.source                rsp_bus
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   kmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kmd_datapath #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_kind         (req_bus.kind),
      .req_source       (req_bus.source_id),
      .req_key_word0    (req_bus.key_word0),
      .req_key_word1    (req_bus.key_word1),
      .req_key_word2    (req_bus.key_word2),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_out_word0    (rsp_bus.out_word0),
      .rsp_out_word1    (rsp_bus.out_word1),
      .rsp_out_word2    (rsp_bus.out_word2),
      .rsp_is_duplicate (rsp_bus.is_duplicate),
      .rsp_fetch_source (rsp_bus.fetch_source),
      .rsp_merge_done   (rsp_bus.merge_done)
   );

endmodule : kway_merge_dedup_unit

`default_nettype wire

// ----- hdl/kmd_ctrl.sv -----
// Controller state machine: sequences accept, evaluate, scan and emit.
`default_nettype none

module kmd_ctrl
   import kmd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  dp_status_type      status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.pop_ready) state_in = ST_SCAN;
            else if (status.all_done) state_in = ST_EMIT_DONE;
            else state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_EMIT_POP;
         end
         ST_EMIT_POP, ST_EMIT_DONE: begin
            if (status.slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_EVAL: begin
            cmd.scan_start = status.pop_ready;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_EMIT_POP: begin
            cmd.emit_pop = status.slot_free;
         end
         ST_EMIT_DONE: begin
            cmd.emit_done = status.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule : kmd_ctrl

`default_nettype wire

// ----- hdl/kmd_datapath.sv -----
// Datapath: head store, source masks, minimum scan, dedup and result register.
`default_nettype none

module kmd_datapath
   import kmd_pkg::*;
#(
   parameter int NUM_SOURCES = NUM_SOURCES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  ctrl_cmd_type               cmd,
   output dp_status_type              status,
   input  wire logic                  csr_write_enable,
   input  wire logic [ACTIVE_W-1:0]   csr_write_data,
   input  wire logic                  req_kind,
   input  wire logic [SOURCE_W-1:0]   req_source,
   input  wire logic [KEY_WORD_W-1:0] req_key_word0,
   input  wire logic [KEY_WORD_W-1:0] req_key_word1,
   input  wire logic [KEY_WORD_W-1:0] req_key_word2,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [KEY_WORD_W-1:0]      rsp_out_word0,
   output logic [KEY_WORD_W-1:0]      rsp_out_word1,
   output logic [KEY_WORD_W-1:0]      rsp_out_word2,
   output logic                       rsp_is_duplicate,
   output logic [SOURCE_W-1:0]        rsp_fetch_source,
   output logic                       rsp_merge_done
);

   localparam int IW = $clog2(NUM_SOURCES);
   localparam int NW = $clog2(NUM_SOURCES + 1);

   // configuration
   logic [ACTIVE_W-1:0]    active_ff;
   logic [NW-1:0]          eff_n;
   logic [NUM_SOURCES-1:0] amask;

   // source state
   logic [NUM_SOURCES-1:0] present_ff;
   logic [NUM_SOURCES-1:0] exhausted_ff;
   logic [NUM_SOURCES-1:0] present_act;
   logic [NUM_SOURCES-1:0] open_act;
   key_type                head_mem [NUM_SOURCES];

   // scan
   logic [IW-1:0]          idx_ff;
   logic                   rd_valid_ff;
   logic [IW-1:0]          rd_idx_ff;
   key_type                rd_data_ff;
   logic                   best_valid_ff;
   logic [IW-1:0]          best_idx_ff;
   key_type                best_key_ff;
   logic                   take_rd;

   // dedup
   key_type                last_ff;
   logic                   last_present_ff;
   logic                   dup;

   // input decode
   logic [IW-1:0]          src_idx;
   logic                   src_in_range;
   logic                   key_write;
   key_type                req_key;

   // result register
   logic                   rsp_valid_ff;
   key_type                rsp_key_ff;
   logic                   rsp_dup_ff;
   logic [SOURCE_W-1:0]    rsp_src_ff;
   logic                   rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_write_enable) begin
         active_ff <= csr_write_data;
      end
   end

   // zero acts as one, anything above the source count is clamped
   always_comb begin
      if (active_ff == '0) begin
         eff_n = NW'(1);
      end else if (int'(active_ff) > NUM_SOURCES) begin
         eff_n = NW'(NUM_SOURCES);
      end else begin
         eff_n = NW'(active_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
         amask[i] = (i < int'(eff_n));
      end
   end

   assign src_idx      = IW'(req_source);
   assign src_in_range = (int'(req_source) < int'(eff_n));
   assign key_write    = cmd.accept && src_in_range && (req_kind == KIND_KEY) &&
                         !exhausted_ff[src_idx] && !present_ff[src_idx];
   assign req_key      = {req_key_word0, req_key_word1, req_key_word2};

   assign present_act  = present_ff & amask;
   assign open_act     = amask & ~exhausted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         exhausted_ff <= '0;
      end else begin
         if (cmd.accept && src_in_range && (req_kind == KIND_EXHAUSTED)) begin
            exhausted_ff[src_idx] <= 1'b1;
         end
         if (key_write) begin
            present_ff[src_idx] <= 1'b1;
         end
         if (cmd.emit_pop) begin
            present_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   // head store: one write port at accept, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (key_write) begin
         head_mem[src_idx] <= req_key;
      end
      if (cmd.scan_step) begin
         rd_data_ff <= head_mem[idx_ff];
      end
   end

   // strict less keeps the lower index on equal keys
   assign take_rd = rd_valid_ff && present_ff[rd_idx_ff] &&
                    (!best_valid_ff || (rd_data_ff < best_key_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_step;
         if (cmd.scan_start) begin
            idx_ff        <= '0;
            best_valid_ff <= 1'b0;
         end else begin
            if (cmd.scan_step) idx_ff <= idx_ff + IW'(1);
            if (take_rd) best_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         rd_idx_ff <= idx_ff;
      end
      if (take_rd) begin
         best_idx_ff <= rd_idx_ff;
         best_key_ff <= rd_data_ff;
      end
   end

   assign dup = last_present_ff && (last_ff == best_key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_present_ff <= 1'b0;
      end else if (cmd.emit_pop && !dup) begin
         last_present_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pop && !dup) begin
         last_ff <= best_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_pop || cmd.emit_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pop) begin
         rsp_key_ff  <= best_key_ff;
         rsp_dup_ff  <= dup;
         rsp_src_ff  <= SOURCE_W'(best_idx_ff);
         rsp_done_ff <= 1'b0;
      end else if (cmd.emit_done) begin
         rsp_key_ff  <= '0;
         rsp_dup_ff  <= 1'b0;
         rsp_src_ff  <= '0;
         rsp_done_ff <= 1'b1;
      end
   end

   assign status.pop_ready = (|present_act) && !(|(open_act & ~present_act));
   assign status.all_done  = !(|open_act) && !(|present_act);
   assign status.scan_last = (idx_ff == IW'(eff_n - NW'(1)));
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_word0    = rsp_key_ff[KEY_W-1 -: KEY_WORD_W];
   assign rsp_out_word1    = rsp_key_ff[KEY_W-KEY_WORD_W-1 -: KEY_WORD_W];
   assign rsp_out_word2    = rsp_key_ff[KEY_WORD_W-1:0];
   assign rsp_is_duplicate = rsp_dup_ff;
   assign rsp_fetch_source = rsp_src_ff;
   assign rsp_merge_done   = rsp_done_ff;

endmodule : kmd_datapath

`default_nettype wire
